>>> sv/bls_pkg.sv
`default_nettype none

package bls_pkg;

    // Fixed field widths.
    localparam int NODE_W = 10;
    localparam int STEP_W = 20;
    localparam int CNT_W  = 11;
    localparam int LB_W   = 5;
    localparam int CFG_W  = 20;

    // Input commands. The fourth code carries no meaning and is dropped.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_command;

    // Configuration register indexes.
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_MAX_STEPS  = 1'b1;

    // Result kinds.
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STEPS = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_B_RD0  = 8'b0000_0100,
        S_B_RD1  = 8'b0000_1000,
        S_B_WR   = 8'b0001_0000,
        S_Q_STEP = 8'b0010_0000,
        S_Q_WAIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic build_init;
        logic query_init;
        logic rd_entry;
        logic rd_mid;
        logic wr_jump;
        logic rd_walk;
        logic walk_take;
        logic step_next;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       build_empty;
        logic       build_last;
        logic       q_err;
        logic       q_end;
        logic       q_bit;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/bls_ctrl.sv
`default_nettype none

module bls_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  bls_pkg::t_stat      i_stat,
    output bls_pkg::t_cmd       o_cmd
);

    bls_pkg::t_state r_state;
    bls_pkg::t_state n_state;

    // The input side is open only while idle.
    assign o_in_stall = (r_state != bls_pkg::S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bls_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bls_pkg::S_DECODE;
                end
            end
            bls_pkg::S_DECODE: begin
                unique case (i_stat.command)
                    bls_pkg::CMD_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = bls_pkg::S_IDLE;
                    end
                    bls_pkg::CMD_BUILD: begin
                        o_cmd.build_init = 1'b1;
                        n_state = i_stat.build_empty ? bls_pkg::S_DONE : bls_pkg::S_B_RD0;
                    end
                    bls_pkg::CMD_QUERY: begin
                        o_cmd.query_init = 1'b1;
                        n_state = i_stat.q_err ? bls_pkg::S_DONE : bls_pkg::S_Q_STEP;
                    end
                    default: begin
                        n_state = bls_pkg::S_IDLE;
                    end
                endcase
            end
            bls_pkg::S_B_RD0: begin
                o_cmd.rd_entry = 1'b1;
                n_state        = bls_pkg::S_B_RD1;
            end
            bls_pkg::S_B_RD1: begin
                o_cmd.rd_mid = 1'b1;
                n_state      = bls_pkg::S_B_WR;
            end
            bls_pkg::S_B_WR: begin
                o_cmd.wr_jump = 1'b1;
                n_state = i_stat.build_last ? bls_pkg::S_DONE : bls_pkg::S_B_RD0;
            end
            bls_pkg::S_Q_STEP: begin
                priority if (i_stat.q_end) begin
                    n_state = bls_pkg::S_DONE;
                end else if (i_stat.q_bit) begin
                    o_cmd.rd_walk = 1'b1;
                    n_state       = bls_pkg::S_Q_WAIT;
                end else begin
                    o_cmd.step_next = 1'b1;
                end
            end
            bls_pkg::S_Q_WAIT: begin
                o_cmd.walk_take = 1'b1;
                n_state         = bls_pkg::S_Q_STEP;
            end
            bls_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bls_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sv/bls_datapath.sv
`default_nettype none

module bls_datapath #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 20
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [bls_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire [1:0]                    i_command,
    input  wire [bls_pkg::NODE_W-1:0]    i_entry_index,
    input  wire [bls_pkg::NODE_W-1:0]    i_entry_next,
    input  wire [bls_pkg::NODE_W-1:0]    i_start_node,
    input  wire [bls_pkg::STEP_W-1:0]    i_steps,
    input  bls_pkg::t_cmd                i_cmd,
    output bls_pkg::t_stat               o_stat,
    input  wire                          i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_kind,
    output logic [bls_pkg::NODE_W-1:0]   o_result_node,
    output logic [1:0]                   o_status
);

    localparam int NW = $clog2(NODES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Map a node value to a table column; values past the table read column zero.
    function automatic logic [NW-1:0] to_col(input logic [bls_pkg::NODE_W-1:0] n);
        logic [16:0] w;
        w = 17'(n);
        if (w >= 17'(NODES)) begin
            w = '0;
        end
        return w[NW-1:0];
    endfunction

    // Map a level number to a table row.
    function automatic logic [LW-1:0] to_row(input logic [bls_pkg::LB_W-1:0] l);
        logic [5:0] w;
        w = 6'(l);
        return w[LW-1:0];
    endfunction

    // Configuration and persistent state.
    logic [bls_pkg::CNT_W-1:0]  r_node_count;
    logic [bls_pkg::STEP_W-1:0] r_max_steps;
    logic [bls_pkg::LB_W-1:0]   r_lb;

    // Captured item fields.
    logic [1:0]                 r_cmd;
    logic [bls_pkg::NODE_W-1:0] r_eidx;
    logic [bls_pkg::NODE_W-1:0] r_enext;
    logic [bls_pkg::NODE_W-1:0] r_start;
    logic [bls_pkg::STEP_W-1:0] r_steps;

    // Working registers.
    logic [bls_pkg::LB_W-1:0]   r_i;
    logic [bls_pkg::LB_W-1:0]   r_k;
    logic [bls_pkg::NODE_W-1:0] r_j;
    logic [bls_pkg::LB_W-1:0]   r_b;
    logic [bls_pkg::NODE_W-1:0] r_node;
    logic                       r_kind;
    logic [1:0]                 r_status;

    // Output register.
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_out_kind;
    logic [bls_pkg::NODE_W-1:0] r_out_node;
    logic [1:0]                 r_out_status;

    // Jump table and its ports.
    logic [bls_pkg::NODE_W-1:0] r_mem [LEVELS][NODES];
    logic [bls_pkg::NODE_W-1:0] r_rd_data;
    logic                       rd_en;
    logic [LW-1:0]              rd_row;
    logic [NW-1:0]              rd_col;
    logic                       wr_en;
    logic [LW-1:0]              wr_row;
    logic [NW-1:0]              wr_col;
    logic [bls_pkg::NODE_W-1:0] wr_data;

    logic [bls_pkg::CNT_W-1:0]  cnt;
    logic [16:0]                nc_wide;
    logic [bls_pkg::LB_W-1:0]   k_need;
    logic [5:0]                 k_raw;
    logic [bls_pkg::LB_W-1:0]   usable;
    logic                       high_bits;
    logic [1:0]                 q_status;
    logic                       load_ok;
    logic                       j_last;

    // Node count in effect.
    always_comb begin
        nc_wide = 17'(r_node_count);
        if (nc_wide > 17'(NODES)) begin
            nc_wide = 17'(NODES);
        end
        cnt = nc_wide[bls_pkg::CNT_W-1:0];
    end

    // Levels a build fills: bit length of max_steps, kept within one and LEVELS.
    always_comb begin
        k_raw = '0;
        for (int b = 0; b < bls_pkg::STEP_W; b++) begin
            if (r_max_steps[b]) begin
                k_raw = 6'(b + 1);
            end
        end
        if (k_raw == 6'd0) begin
            k_raw = 6'd1;
        end
        if (k_raw > 6'(LEVELS)) begin
            k_raw = 6'(LEVELS);
        end
        k_need = k_raw[bls_pkg::LB_W-1:0];
    end

    // Query checks against the levels that are usable now.
    always_comb begin
        usable    = (r_lb == '0) ? bls_pkg::LB_W'(1) : r_lb;
        high_bits = 1'b0;
        for (int b = 0; b < bls_pkg::STEP_W; b++) begin
            if (bls_pkg::LB_W'(b) >= usable && r_steps[b]) begin
                high_bits = 1'b1;
            end
        end
        priority if (r_steps > r_max_steps || high_bits) begin
            q_status = bls_pkg::ST_STEPS;
        end else if (bls_pkg::CNT_W'(r_start) >= cnt) begin
            q_status = bls_pkg::ST_RANGE;
        end else begin
            q_status = bls_pkg::ST_OK;
        end
    end

    assign load_ok = (bls_pkg::CNT_W'(r_eidx) < cnt) && (bls_pkg::CNT_W'(r_enext) < cnt);
    assign j_last  = (bls_pkg::CNT_W'(r_j) + bls_pkg::CNT_W'(1)) == cnt;

    // Status to the controller.
    always_comb begin
        o_stat.command     = r_cmd;
        o_stat.build_empty = (k_need < bls_pkg::LB_W'(2)) || (cnt == '0);
        o_stat.build_last  = j_last && ((6'(r_i) + 6'd2) >= 6'(r_k));
        o_stat.q_err       = (q_status != bls_pkg::ST_OK);
        o_stat.q_end       = (r_b >= usable);
        o_stat.q_bit       = (r_b < bls_pkg::LB_W'(bls_pkg::STEP_W)) ? r_steps[r_b] : 1'b0;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    // Table port selection.
    always_comb begin
        rd_en   = i_cmd.rd_entry || i_cmd.rd_mid || i_cmd.rd_walk;
        rd_row  = i_cmd.rd_walk ? to_row(r_b) : to_row(r_i);
        priority if (i_cmd.rd_entry) begin
            rd_col = to_col(r_j);
        end else if (i_cmd.rd_mid) begin
            rd_col = to_col(r_rd_data);
        end else begin
            rd_col = to_col(r_node);
        end
        wr_en   = (i_cmd.load_wr && load_ok) || i_cmd.wr_jump;
        wr_row  = i_cmd.wr_jump ? to_row(r_i + bls_pkg::LB_W'(1)) : to_row('0);
        wr_col  = i_cmd.wr_jump ? to_col(r_j) : to_col(r_eidx);
        wr_data = i_cmd.wr_jump ? r_rd_data : r_enext;
    end

    // Jump table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row][wr_col] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_row][rd_col];
        end
    end

    // Configuration registers and levels built.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= bls_pkg::CNT_W'(1024);
            r_max_steps  <= '1;
            r_lb         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bls_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[bls_pkg::CNT_W-1:0];
                    bls_pkg::CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_wr && load_ok) begin
                r_lb <= '0;
            end else if (i_cmd.build_init) begin
                r_lb <= k_need;
            end
        end
    end

    // Item capture and the working registers of build and query.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_eidx  <= i_entry_index;
            r_enext <= i_entry_next;
            r_start <= i_start_node;
            r_steps <= i_steps;
        end
        if (i_cmd.build_init) begin
            r_k      <= k_need;
            r_i      <= '0;
            r_j      <= '0;
            r_kind   <= bls_pkg::KIND_BUILD;
            r_status <= bls_pkg::ST_OK;
        end
        if (i_cmd.wr_jump) begin
            if (j_last) begin
                r_j <= '0;
                r_i <= r_i + bls_pkg::LB_W'(1);
            end else begin
                r_j <= r_j + bls_pkg::NODE_W'(1);
            end
        end
        if (i_cmd.query_init) begin
            r_node   <= r_start;
            r_b      <= '0;
            r_kind   <= bls_pkg::KIND_QUERY;
            r_status <= q_status;
        end
        if (i_cmd.walk_take) begin
            r_node <= r_rd_data;
        end
        if (i_cmd.walk_take || i_cmd.step_next) begin
            r_b <= r_b + bls_pkg::LB_W'(1);
        end
    end

    // Output register: holds a result beat until the receiver takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind   <= r_kind;
            r_out_status <= r_status;
            r_out_node   <= (r_kind == bls_pkg::KIND_QUERY && r_status == bls_pkg::ST_OK)
                            ? r_node : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_result_node = r_out_node;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

>>> sv/binary_lifting_successor_core.sv
// Binary lifting successor core.
// Input channel (i_in_valid / o_in_stall) takes one command beat at a time:
// load writes a node's successor into level zero of the jump table, build
// fills the higher levels, query walks from a start node by a step count.
// Output channel (o_out_valid / i_out_stall) returns one beat per build or
// query; loads and the unused command return nothing.
// Each query step handles one step bit, up to the levels built; a set
// bit adds a jump, a dependent read of the single table read port, and a
// query that fails its checks goes straight to its result. A build fills
// each table entry of each level above zero with three dependent table
// accesses: a read of the entry, a read of the entry it names, and a write
// one level up.
// The output register lets the next item be taken while a result beat waits;
// if the receiver stalls, a finished result waits in the controller until
// the output register is free, and the input stays stalled meanwhile.
// Reset (synchronous, active low) returns the controller to idle, clears
// the output valid, marks no levels built and restores node_count to 1024
// and max_steps to all ones. The jump table is not cleared; no reset sweep.
// Configuration writes take effect at once and must happen while idle.
`default_nettype none

module binary_lifting_successor_core #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 20
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [bls_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [1:0]                    i_command,
    input  wire [bls_pkg::NODE_W-1:0]    i_entry_index,
    input  wire [bls_pkg::NODE_W-1:0]    i_entry_next,
    input  wire [bls_pkg::NODE_W-1:0]    i_start_node,
    input  wire [bls_pkg::STEP_W-1:0]    i_steps,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_kind,
    output logic [bls_pkg::NODE_W-1:0]   o_result_node,
    output logic [1:0]                   o_status
);

    bls_pkg::t_cmd  s_cmd;
    bls_pkg::t_stat s_stat;

    // Sequencer.
    bls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // Jump table, registers and output stage.
    bls_datapath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_next  (i_entry_next),
        .i_start_node  (i_start_node),
        .i_steps       (i_steps),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_result_node (o_result_node),
        .o_status      (o_status)
    );

`ifndef ASSERT_OFF
    // An accepted beat keeps the input closed in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A result is loaded only when the output register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a waiting beat");

    // Output valid rises only from a result load.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s_cmd.out_load))
        else $error("output valid rose without a result load");
`endif

endmodule

`default_nettype wire

>>> tb/successor_checker.sv
`timescale 1ns / 100ps

module successor_checker #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bls_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [bls_pkg::NODE_W-1:0]    i_entry_index,
    input  logic [bls_pkg::NODE_W-1:0]    i_entry_next,
    input  logic [bls_pkg::NODE_W-1:0]    i_start_node,
    input  logic [bls_pkg::STEP_W-1:0]    i_steps,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_kind,
    input  logic [bls_pkg::NODE_W-1:0]    i_result_node,
    input  logic [1:0]                    i_status,
    output int                            o_fail_count,
    output int                            o_pending
);
    import bls_pkg::*;

    // One result beat as the block should present it.
    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] node;
        logic [1:0]        status;
    } t_answer;

    t_answer           answers_due[$];
    logic [NODE_W-1:0] jumps [LEVELS][NODES];
    logic [CNT_W-1:0]  node_count;
    logic [STEP_W-1:0] step_limit;
    int unsigned       levels_ready;
    int                fail_total = 0;
    int                due_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;

    // Nodes in use, capped at the table size.
    function automatic int unsigned live_nodes();
        if (node_count < NODES) begin
            return node_count;
        end
        return NODES;
    endfunction

    // Smallest level count whose jumps together reach the step limit, kept within one and LEVELS.
    function automatic int unsigned levels_for_limit();
        int unsigned k;
        k = 0;
        while (k < 21 && (64'd1 << k) <= step_limit) begin
            k++;
        end
        if (k < 1) begin
            k = 1;
        end
        if (k > LEVELS) begin
            k = LEVELS;
        end
        return k;
    endfunction

    // Each higher level is the successor's successor one level below.
    task automatic build_levels();
        int unsigned depth;
        int unsigned live;
        int unsigned mid;
        depth = levels_for_limit();
        live  = live_nodes();
        for (int unsigned lvl = 0; lvl + 1 < depth; lvl++) begin
            for (int unsigned j = 0; j < live; j++) begin
                mid = jumps[lvl][j];
                if (mid >= NODES) begin
                    mid = 0;
                end
                jumps[lvl + 1][j] = jumps[lvl][mid];
            end
        end
        levels_ready = depth;
    endtask

    // Walks from the start node, one jump per set bit of the step count.
    function automatic t_answer answer_query(logic [NODE_W-1:0] start,
                                             logic [STEP_W-1:0] steps);
        t_answer     ans;
        int unsigned usable;
        int unsigned here;
        ans.kind   = KIND_QUERY;
        ans.node   = '0;
        ans.status = ST_OK;
        usable = (levels_ready < 1) ? 1 : levels_ready;
        if (usable > LEVELS) begin
            usable = LEVELS;
        end
        if (steps > step_limit || (usable < STEP_W && (steps >> usable) != 0)) begin
            ans.status = ST_STEPS;
        end else if (start >= live_nodes()) begin
            ans.status = ST_RANGE;
        end else begin
            here = start;
            for (int unsigned b = 0; b < usable && b < STEP_W; b++) begin
                if (steps[b]) begin
                    if (here >= NODES) begin
                        here = 0;
                    end
                    here = jumps[b][here];
                end
            end
            ans.node = here[NODE_W-1:0];
        end
        return ans;
    endfunction

    task automatic log_failure(string text);
        if (fail_total < 10) begin
            $display("[%0t] %s", $time, text);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            // Reset leaves the table contents alone in the block; zero is a
            // stand-in since unwritten entries are never read.
            answers_due.delete();
            for (int lvl = 0; lvl < LEVELS; lvl++) begin
                for (int j = 0; j < NODES; j++) begin
                    jumps[lvl][j] = '0;
                end
            end
            levels_ready = 0;
            node_count   = 11'd1024;
            step_limit   = '1;
        end else begin
            // Register writes take effect at once.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NODE_COUNT) begin
                    node_count = i_cfg_data[CNT_W-1:0];
                end else begin
                    step_limit = i_cfg_data[STEP_W-1:0];
                end
            end

            // A result beat is matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got.kind   = i_kind;
                got.node   = i_result_node;
                got.status = i_status;
                if (answers_due.size() == 0) begin
                    log_failure($sformatf("unexpected result beat: kind %0d node %0d status %0d",
                                          got.kind, got.node, got.status));
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        log_failure($sformatf(
                            "result mismatch: expected kind %0d node %0d status %0d, got %0d %0d %0d",
                            want.kind, want.node, want.status, got.kind, got.node, got.status));
                    end
                end
            end

            // Each accepted command beat updates the state and queues its answer.
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_LOAD: begin
                        if (i_entry_index < live_nodes() && i_entry_next < live_nodes()) begin
                            jumps[0][i_entry_index] = i_entry_next;
                            levels_ready = 0;
                        end
                    end
                    CMD_BUILD: begin
                        build_levels();
                        want.kind   = KIND_BUILD;
                        want.node   = '0;
                        want.status = ST_OK;
                        answers_due.push_back(want);
                    end
                    CMD_QUERY: begin
                        answers_due.push_back(answer_query(i_start_node, i_steps));
                    end
                    default: begin
                    end
                endcase
            end
        end
        due_count = answers_due.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import bls_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 20;

    // The fourth command code has no meaning and must be dropped by the block.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 40;
    localparam int STEP_MAX      = 20'hFFFFF;
    localparam int NODE_MAX      = 1023;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_index   = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data    = '0;
    logic                i_in_valid    = 1'b0;
    logic [1:0]          i_command     = '0;
    logic [NODE_W-1:0]   i_entry_index = '0;
    logic [NODE_W-1:0]   i_entry_next  = '0;
    logic [NODE_W-1:0]   i_start_node  = '0;
    logic [STEP_W-1:0]   i_steps       = '0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_kind;
    logic [NODE_W-1:0]   o_result_node;
    logic [1:0]          o_status;

    int                  fail_count;
    int                  pending;
    int                  cycle_count   = 0;
    int                  tx_idle_pct   = 0;
    int                  rx_stall_pct  = 0;
    bit                  hold_request  = 1'b0;
    int                  hold_left     = 0;

    // What the stimulus knows of the map, so that it never walks into an
    // entry that was never loaded.
    int unsigned         live_cnt      = 1024;
    logic [STEP_W-1:0]   step_cap      = '1;
    bit                  jumps_built   = 1'b0;
    bit                  node_loaded [NODES];
    int unsigned         loaded_nodes[$];

    binary_lifting_successor_core #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_next  (i_entry_next),
        .i_start_node  (i_start_node),
        .i_steps       (i_steps),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_result_node (o_result_node),
        .o_status      (o_status)
    );

    successor_checker #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_next  (i_entry_next),
        .i_start_node  (i_start_node),
        .i_steps       (i_steps),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_kind        (o_kind),
        .i_result_node (o_result_node),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: random stalls, or one long hold-off when asked for.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_lifting_successor_core regression: fail");
            $finish;
        end
    end

    // Offers one beat, after optional idle cycles, and holds it until taken.
    task automatic push_beat(logic [1:0] cmd, logic [NODE_W-1:0] idx,
                             logic [NODE_W-1:0] nxt, logic [NODE_W-1:0] start,
                             logic [STEP_W-1:0] steps);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_entry_next  <= nxt;
        i_start_node  <= start;
        i_steps       <= steps;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task automatic send_load(int unsigned idx, int unsigned nxt);
        push_beat(CMD_LOAD, idx[NODE_W-1:0], nxt[NODE_W-1:0],
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  STEP_W'($urandom_range(0, STEP_MAX)));
        if (idx < live_cnt && nxt < live_cnt) begin
            if (!node_loaded[idx]) begin
                node_loaded[idx] = 1'b1;
                loaded_nodes.push_back(idx);
            end
            jumps_built = 1'b0;
        end
    endtask

    task automatic send_build();
        push_beat(CMD_BUILD, NODE_W'($urandom_range(0, NODE_MAX)),
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  STEP_W'($urandom_range(0, STEP_MAX)));
        jumps_built = 1'b1;
    endtask

    task automatic send_query(int unsigned start, int unsigned steps);
        push_beat(CMD_QUERY, NODE_W'($urandom_range(0, NODE_MAX)),
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  start[NODE_W-1:0], steps[STEP_W-1:0]);
    endtask

    task automatic send_unused();
        push_beat(CMD_UNUSED, NODE_W'($urandom_range(0, NODE_MAX)),
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  NODE_W'($urandom_range(0, NODE_MAX)),
                  STEP_W'($urandom_range(0, STEP_MAX)));
    endtask

    // A step count the block should accept; only level zero counts before a build.
    function automatic int unsigned valid_steps();
        int unsigned cap;
        cap = step_cap;
        if (!jumps_built && cap > 1) begin
            cap = 1;
        end
        if ($urandom_range(0, 9) == 0) begin
            return cap;
        end
        return $urandom_range(0, cap);
    endfunction

    // Both registers in back-to-back cycles, with the block idle.
    task automatic program_limits(int unsigned count, int unsigned cap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NODE_COUNT;
        i_cfg_data  <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_STEPS;
        i_cfg_data  <= CFG_W'(cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        live_cnt = (count < NODES) ? count : NODES;
        step_cap = STEP_W'(cap);
    endtask

    // Stops offering beats until every answer is back and a load has had
    // time to finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Loads a random successor for every node in use.
    task automatic fill_map();
        for (int unsigned j = 0; j < live_cnt; j++) begin
            send_load(j, $urandom_range(0, live_cnt - 1));
        end
    endtask

    // Random traffic. In the wide setting only the start node's own entry
    // may be read, so walks there take at most one step.
    task automatic run_mix(int items, bit wide, int hold_at);
        int pick;
        int sub;
        int build_pct;
        for (int n = 0; n < items; n++) begin
            if (n == hold_at) begin
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (wide) begin
                if (pick < 30) begin
                    send_load($urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX));
                end else if (pick < 34) begin
                    send_build();
                end else if (pick < 37) begin
                    send_unused();
                end else if (pick < 80 && loaded_nodes.size() > 0) begin
                    send_query(loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)],
                               $urandom_range(0, 1));
                end else if (pick < 90) begin
                    send_query($urandom_range(0, NODE_MAX), $urandom_range(2, STEP_MAX));
                end else begin
                    send_query($urandom_range(0, NODE_MAX), 0);
                end
            end else begin
                build_pct = jumps_built ? 3 : 30;
                sub = $urandom_range(0, 99);
                if (pick < 9) begin
                    send_load($urandom_range(0, live_cnt - 1), $urandom_range(0, live_cnt - 1));
                end else if (pick < 12) begin
                    send_load($urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX));
                end else if (pick < 12 + build_pct) begin
                    send_build();
                end else if (pick < 15 + build_pct) begin
                    send_unused();
                end else if (sub < 70) begin
                    send_query($urandom_range(0, live_cnt - 1), valid_steps());
                end else if (sub < 85) begin
                    send_query($urandom_range(0, NODE_MAX), $urandom_range(0, STEP_MAX));
                end else if (sub < 93) begin
                    send_query($urandom_range(0, NODE_MAX), valid_steps());
                end else begin
                    send_query($urandom_range(0, NODE_MAX), 0);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver stalls heavily.
        tx_idle_pct  = 26;
        rx_stall_pct = 69;

        // Directed: an eight-node ring-like map with a step limit of fifteen.
        program_limits(8, 15);
        for (int unsigned j = 0; j < 8; j++) begin
            send_load(j, (3 * j + 1) % 8);
        end
        send_query(3, 0);                   // zero steps returns the start node
        send_query(0, 1);                   // level zero is usable before a build
        send_query(0, 2);                   // level one not built yet
        send_build();
        send_query(7, 15);                  // every step bit up to the limit
        send_query(0, 16);                  // one past the step limit
        send_query(8, 5);                   // start node out of range
        send_query(NODE_MAX, STEP_MAX);     // step error wins over range error
        send_query(NODE_MAX, 0);
        send_load(NODE_MAX, 0);             // out-of-range loads are dropped
        send_load(0, NODE_MAX);
        send_query(5, 12);                  // levels still built
        push_beat(CMD_UNUSED, '1, '1, '1, '1);
        send_load(2, 2);                    // a load after a build discards the levels
        send_query(2, 3);
        send_query(2, 1);
        send_build();
        send_query(2, 15);
        send_query(6, 9);
        settle();

        // Smallest map, zero step limit.
        program_limits(1, 0);
        fill_map();
        run_mix(100, 1'b0, -1);
        settle();

        // Full step range over a small map, so every level gets built.
        program_limits(37, STEP_MAX);
        fill_map();
        run_mix(150, 1'b0, -1);
        settle();

        // Sender idles heavily, receiver stalls lightly.
        tx_idle_pct  = 69;
        rx_stall_pct = 26;

        // Largest map with a one-step limit; only part of it is loaded.
        program_limits(1024, 1);
        repeat (48) send_load($urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX));
        run_mix(250, 1'b1, -1);
        settle();

        program_limits(200, 300);
        fill_map();
        run_mix(150, 1'b0, -1);
        settle();

        // No idling on either side; one long receiver hold-off fills the block.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        program_limits(16, 1000);
        fill_map();
        run_mix(300, 1'b0, 60);
        settle();

        program_limits(5, 6);
        fill_map();
        run_mix(150, 1'b0, -1);
        settle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("binary_lifting_successor_core regression: pass");
        end else begin
            $display("binary_lifting_successor_core regression: fail");
        end
        $finish;
    end

endmodule
